### hw/rtl/mlp_sgd_pkg.sv
// Shared types, constants and helper functions of the online-trained MLP engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package mlp_sgd_pkg;

  // network shape
  localparam int H       = 25;
  localparam int N_OUT   = 6;
  localparam int N_WORDS = 9 * H + 6;

  // widths
  localparam int AW     = 9;
  localparam int MW     = $clog2(N_WORDS);
  localparam int KW     = $clog2(H + 1);
  localparam int KI     = (H > 1) ? $clog2(H) : 1;
  localparam int LR_W   = 24;
  localparam int OP_W   = 34;
  localparam int PW     = 2 * OP_W;
  localparam int RW     = PW - 24;
  localparam int ACC_W  = 48;

  localparam logic [LR_W-1:0]          LR_RESET = 24'd16777;
  localparam logic signed [OP_W-1:0]   ONE      = 34'sh1000000;
  localparam logic signed [PW-1:0]     RND_HALF = 68'sh800000;

  typedef enum logic [1:0] {
    MODE_INFER = 2'd0,
    MODE_TRAIN = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_FH,
    ST_FO,
    ST_DS,
    ST_W2,
    ST_OB,
    ST_TK,
    ST_W1,
    ST_DONE
  } st_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] feature_a;
    logic signed [31:0] feature_b;
    logic signed [31:0] target_0;
    logic signed [31:0] target_1;
    logic signed [31:0] target_2;
    logic signed [31:0] target_3;
    logic signed [31:0] target_4;
    logic signed [31:0] target_5;
    logic [AW-1:0]      weight_index;
    logic signed [31:0] weight_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_0;
    logic signed [31:0] out_1;
    logic signed [31:0] out_2;
    logic signed [31:0] out_3;
    logic signed [31:0] out_4;
    logic signed [31:0] out_5;
    logic [30:0]        max_abs_error;
    logic signed [31:0] read_word;
  } out_item_t;

  // clamp a wide value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(2147483647);
    lo = -hi - ACC_W'(1);
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // weight word addresses
  function automatic logic [AW-1:0] a_w1(input logic i, input logic [KW-1:0] k);
    return AW'(int'(i) * H + int'(k));
  endfunction

  function automatic logic [AW-1:0] a_w2(input logic [KW-1:0] k, input logic [2:0] j);
    return AW'(2 * H + int'(j) * H + int'(k));
  endfunction

  function automatic logic [AW-1:0] a_hb(input logic [KW-1:0] k);
    return AW'(8 * H + int'(k));
  endfunction

  function automatic logic [AW-1:0] a_ob(input logic [2:0] j);
    return AW'(9 * H + int'(j));
  endfunction

endpackage

### hw/rtl/mlp_sgd_wmem.sv
// Weight store: one write port, one registered read port, a valid bit per word.
// Depends on mlp_sgd_pkg for the depth and address width.
`timescale 1ns / 1ps

module mlp_sgd_wmem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mlp_sgd_pkg::AW-1:0]    rd_addr,
  output logic signed [31:0]            rd_data,
  input  logic                          wr_en,
  input  logic [mlp_sgd_pkg::AW-1:0]    wr_addr,
  input  logic signed [31:0]            wr_data
);

  logic signed [31:0]                  mem [mlp_sgd_pkg::N_WORDS];
  logic [mlp_sgd_pkg::N_WORDS-1:0]     vld_r;
  logic signed [31:0]                  rdata_r;
  logic                                rok_r;
  logic                                rd_in;

  assign rd_in = rd_addr < mlp_sgd_pkg::AW'(mlp_sgd_pkg::N_WORDS);

  // store the word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[mlp_sgd_pkg::MW-1:0]] <= wr_data;
    end
    rdata_r <= mem[rd_addr[mlp_sgd_pkg::MW-1:0]];
  end

  // mark written words; unwritten words read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr[mlp_sgd_pkg::MW-1:0]] <= 1'b1;
      end
      rok_r <= rd_in && vld_r[rd_addr[mlp_sgd_pkg::MW-1:0]];
    end
  end

  assign rd_data = rok_r ? rdata_r : 32'sd0;

endmodule

### hw/rtl/mlp_sgd_mac.sv
// Shared multiplier with round-half-up rescale to 24 fraction bits, two stages.
// Depends on mlp_sgd_pkg for operand and result widths.
`timescale 1ns / 1ps

module mlp_sgd_mac (
  input  logic                               clk,
  input  logic signed [mlp_sgd_pkg::OP_W-1:0] op_a,
  input  logic signed [mlp_sgd_pkg::OP_W-1:0] op_b,
  output logic signed [mlp_sgd_pkg::RW-1:0]   rnd
);

  logic signed [mlp_sgd_pkg::PW-1:0] prod_r;
  logic signed [mlp_sgd_pkg::PW-1:0] sum;

  assign sum = prod_r + mlp_sgd_pkg::RND_HALF;

  // multiply, then round and drop the low fraction bits
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    rnd    <= mlp_sgd_pkg::RW'(sum >>> 24);
  end

endmodule

### hw/rtl/mlp_online_sgd_engine.sv
// Top level: sequencer and datapath of the 2-input, ReLU-hidden, 6-output network.
// Depends on mlp_sgd_pkg, mlp_sgd_wmem and mlp_sgd_mac.
//
//  port group  dir   handshake              payload
//  in_         in    in_valid / in_stall    in_item  (mlp_sgd_pkg::in_item_t)
//  out_        out   out_valid / out_stall  out_item (mlp_sgd_pkg::out_item_t)
//  cfg_        in    cfg_valid / cfg_ready  cfg_data (learning rate, Q0.24)
//
// One item at a time. Infer sums three terms per hidden unit (bias and two
// features) and H+1 terms per output (bias and H hidden values), then loads
// the result. Train then updates the output layer (a step per output, each of
// its weights and its bias), skips each inactive hidden unit and updates the
// weights and bias of each active one.
// Reset (rst_n, synchronous) clears the weight valid bits, so all weights read
// zero, and sets the learning rate to 16777. A stalled result holds in the
// output register; the sequencer waits for it before the next item is taken.
`timescale 1ns / 1ps

module mlp_online_sgd_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mlp_sgd_pkg::in_item_t       in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mlp_sgd_pkg::out_item_t      out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mlp_sgd_pkg::LR_W-1:0] cfg_data
);

  localparam int KW   = mlp_sgd_pkg::KW;
  localparam int KI   = mlp_sgd_pkg::KI;
  localparam int ACCW = mlp_sgd_pkg::ACC_W;
  localparam int OPW  = mlp_sgd_pkg::OP_W;

  mlp_sgd_pkg::st_t              st_r, st_nxt;
  logic [2:0]                    c_r, c_nxt;
  logic [KW-1:0]                 k_r, k_nxt;
  logic [1:0]                    n_r, n_nxt;
  logic [2:0]                    j_r, j_nxt;
  logic [mlp_sgd_pkg::LR_W-1:0]  lr_r;
  logic                          out_valid_r;
  mlp_sgd_pkg::out_item_t        out_item_r;
  mlp_sgd_pkg::in_item_t         item_r;

  logic signed [31:0]            h_r [mlp_sgd_pkg::H];
  logic signed [ACCW-1:0]        e_r [mlp_sgd_pkg::H];
  logic signed [31:0]            y_r [mlp_sgd_pkg::N_OUT];
  logic signed [ACCW-1:0]        acc_r;
  logic signed [31:0]            delta_r;
  logic signed [OPW-1:0]         s_r;
  logic signed [OPW-1:0]         t_r;
  logic signed [31:0]            wtmp_r;
  logic signed [31:0]            wnew_r;
  logic [32:0]                   maxerr_r;
  logic signed [31:0]            rdw_r;

  logic [mlp_sgd_pkg::AW-1:0]    rd_addr;
  logic signed [31:0]            rd_data;
  logic                          wr_en;
  logic [mlp_sgd_pkg::AW-1:0]    wr_addr;
  logic signed [31:0]            wr_data;
  logic signed [OPW-1:0]         mac_a;
  logic signed [OPW-1:0]         mac_b;
  logic signed [mlp_sgd_pkg::RW-1:0] rnd;
  logic                          done_load;

  logic [KW-1:0]                 kprev;
  logic signed [31:0]            hk;
  logic signed [31:0]            hprev;
  logic signed [ACCW-1:0]        ek;
  logic signed [31:0]            tgt;
  logic signed [32:0]            diff;
  logic [32:0]                   mag;
  logic signed [31:0]            delta_c;
  logic signed [OPW-1:0]         lr_op;
  logic                          acc_first;
  logic signed [ACCW-1:0]        acc_sum;
  logic signed [31:0]            w_upd;
  logic                          accept;
  mlp_sgd_pkg::out_item_t        res;

  mlp_sgd_wmem u_wmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mlp_sgd_mac u_mac (
    .clk  (clk),
    .op_a (mac_a),
    .op_b (mac_b),
    .rnd  (rnd)
  );

  assign in_stall  = (st_r != mlp_sgd_pkg::ST_IDLE);
  assign cfg_ready = (st_r == mlp_sgd_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // operand picks shared by the sequencer and the datapath
  assign kprev   = k_r - 1'b1;
  assign hk      = h_r[k_r[KI-1:0]];
  assign hprev   = h_r[kprev[KI-1:0]];
  assign ek      = e_r[k_r[KI-1:0]];
  assign lr_op   = $signed({{(OPW - mlp_sgd_pkg::LR_W){1'b0}}, lr_r});

  always_comb begin
    case (j_r)
      3'd0:    tgt = item_r.target_0;
      3'd1:    tgt = item_r.target_1;
      3'd2:    tgt = item_r.target_2;
      3'd3:    tgt = item_r.target_3;
      3'd4:    tgt = item_r.target_4;
      default: tgt = item_r.target_5;
    endcase
  end

  assign diff    = 33'(tgt) - 33'(y_r[j_r]);
  assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
  assign delta_c = mlp_sgd_pkg::sat32(ACCW'(diff));

  assign acc_first = (st_r == mlp_sgd_pkg::ST_FH) ? (n_r == 2'd0) : (k_r == '0);
  assign acc_sum   = (acc_first ? ACCW'(0) : acc_r) + ACCW'(rnd);
  assign w_upd     = mlp_sgd_pkg::sat32(ACCW'(wtmp_r) + ACCW'(rnd));

  // next state, memory and multiplier control
  always_comb begin
    st_nxt    = st_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = 32'sd0;
    mac_a     = '0;
    mac_b     = '0;
    done_load = 1'b0;
    case (st_r)
      mlp_sgd_pkg::ST_IDLE: begin
        if (in_valid) begin
          c_nxt = '0;
          k_nxt = '0;
          n_nxt = '0;
          j_nxt = '0;
          case (in_item.mode)
            mlp_sgd_pkg::MODE_WRITE: st_nxt = mlp_sgd_pkg::ST_WR;
            mlp_sgd_pkg::MODE_READ:  st_nxt = mlp_sgd_pkg::ST_RD;
            default:                 st_nxt = mlp_sgd_pkg::ST_FH;
          endcase
        end
      end
      mlp_sgd_pkg::ST_WR: begin
        wr_en   = item_r.weight_index < mlp_sgd_pkg::AW'(mlp_sgd_pkg::N_WORDS);
        wr_addr = item_r.weight_index;
        wr_data = item_r.weight_value;
        st_nxt  = mlp_sgd_pkg::ST_DONE;
      end
      mlp_sgd_pkg::ST_RD: begin
        rd_addr = item_r.weight_index;
        if (c_r == 3'd0) c_nxt = 3'd1;
        else st_nxt = mlp_sgd_pkg::ST_DONE;
      end
      mlp_sgd_pkg::ST_FH: begin
        case (c_r)
          3'd0: begin
            case (n_r)
              2'd0:    rd_addr = mlp_sgd_pkg::a_hb(k_r);
              2'd1:    rd_addr = mlp_sgd_pkg::a_w1(1'b0, k_r);
              default: rd_addr = mlp_sgd_pkg::a_w1(1'b1, k_r);
            endcase
            c_nxt = 3'd1;
          end
          3'd1: begin
            mac_a = OPW'(rd_data);
            case (n_r)
              2'd0:    mac_b = mlp_sgd_pkg::ONE;
              2'd1:    mac_b = OPW'(item_r.feature_a);
              default: mac_b = OPW'(item_r.feature_b);
            endcase
            c_nxt = 3'd2;
          end
          3'd2: c_nxt = 3'd3;
          default: begin
            c_nxt = 3'd0;
            if (n_r == 2'd2) begin
              n_nxt = 2'd0;
              if (k_r == KW'(mlp_sgd_pkg::H - 1)) begin
                k_nxt  = '0;
                j_nxt  = '0;
                st_nxt = mlp_sgd_pkg::ST_FO;
              end else begin
                k_nxt = k_r + 1'b1;
              end
            end else begin
              n_nxt = n_r + 1'b1;
            end
          end
        endcase
      end
      mlp_sgd_pkg::ST_FO: begin
        case (c_r)
          3'd0: begin
            rd_addr = (k_r == '0) ? mlp_sgd_pkg::a_ob(j_r) : mlp_sgd_pkg::a_w2(kprev, j_r);
            c_nxt   = 3'd1;
          end
          3'd1: begin
            mac_a = OPW'(rd_data);
            mac_b = (k_r == '0) ? mlp_sgd_pkg::ONE : OPW'(hprev);
            c_nxt = 3'd2;
          end
          3'd2: c_nxt = 3'd3;
          default: begin
            c_nxt = 3'd0;
            if (k_r == KW'(mlp_sgd_pkg::H)) begin
              k_nxt = '0;
              if (j_r == 3'(mlp_sgd_pkg::N_OUT - 1)) begin
                j_nxt  = '0;
                st_nxt = (item_r.mode == mlp_sgd_pkg::MODE_TRAIN) ?
                         mlp_sgd_pkg::ST_DS : mlp_sgd_pkg::ST_DONE;
              end else begin
                j_nxt = j_r + 1'b1;
              end
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        endcase
      end
      mlp_sgd_pkg::ST_DS: begin
        case (c_r)
          3'd0: begin
            mac_a = lr_op;
            mac_b = OPW'(delta_c);
            c_nxt = 3'd1;
          end
          3'd1: c_nxt = 3'd2;
          default: begin
            c_nxt  = 3'd0;
            k_nxt  = '0;
            st_nxt = mlp_sgd_pkg::ST_W2;
          end
        endcase
      end
      mlp_sgd_pkg::ST_W2: begin
        case (c_r)
          3'd0: begin
            rd_addr = mlp_sgd_pkg::a_w2(k_r, j_r);
            c_nxt   = 3'd1;
          end
          3'd1: begin
            mac_a = s_r;
            mac_b = OPW'(hk);
            c_nxt = 3'd2;
          end
          3'd2: c_nxt = 3'd3;
          3'd3: begin
            wr_en   = 1'b1;
            wr_addr = mlp_sgd_pkg::a_w2(k_r, j_r);
            wr_data = w_upd;
            c_nxt   = 3'd4;
          end
          3'd4: begin
            mac_a = OPW'(delta_r);
            mac_b = OPW'(wnew_r);
            c_nxt = 3'd5;
          end
          3'd5: c_nxt = 3'd6;
          default: begin
            c_nxt = 3'd0;
            if (k_r == KW'(mlp_sgd_pkg::H - 1)) begin
              k_nxt  = '0;
              st_nxt = mlp_sgd_pkg::ST_OB;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        endcase
      end
      mlp_sgd_pkg::ST_OB: begin
        rd_addr = mlp_sgd_pkg::a_ob(j_r);
        if (c_r == 3'd0) begin
          c_nxt = 3'd1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = mlp_sgd_pkg::a_ob(j_r);
          wr_data = mlp_sgd_pkg::sat32(ACCW'(rd_data) + ACCW'(s_r));
          c_nxt   = 3'd0;
          if (j_r == 3'(mlp_sgd_pkg::N_OUT - 1)) begin
            j_nxt  = '0;
            k_nxt  = '0;
            st_nxt = mlp_sgd_pkg::ST_TK;
          end else begin
            j_nxt  = j_r + 1'b1;
            st_nxt = mlp_sgd_pkg::ST_DS;
          end
        end
      end
      mlp_sgd_pkg::ST_TK: begin
        case (c_r)
          3'd0: begin
            if (hk == 32'sd0) begin
              // skip units that were not active
              if (k_r == KW'(mlp_sgd_pkg::H - 1)) st_nxt = mlp_sgd_pkg::ST_DONE;
              else k_nxt = k_r + 1'b1;
            end else begin
              mac_a = lr_op;
              mac_b = OPW'(mlp_sgd_pkg::sat32(ek));
              c_nxt = 3'd1;
            end
          end
          3'd1: c_nxt = 3'd2;
          default: begin
            c_nxt  = 3'd0;
            n_nxt  = 2'd0;
            st_nxt = mlp_sgd_pkg::ST_W1;
          end
        endcase
      end
      mlp_sgd_pkg::ST_W1: begin
        case (n_r)
          2'd0:    wr_addr = mlp_sgd_pkg::a_w1(1'b0, k_r);
          2'd1:    wr_addr = mlp_sgd_pkg::a_w1(1'b1, k_r);
          default: wr_addr = mlp_sgd_pkg::a_hb(k_r);
        endcase
        case (c_r)
          3'd0: begin
            rd_addr = wr_addr;
            c_nxt   = 3'd1;
          end
          3'd1: begin
            mac_a = t_r;
            case (n_r)
              2'd0:    mac_b = OPW'(item_r.feature_a);
              2'd1:    mac_b = OPW'(item_r.feature_b);
              default: mac_b = mlp_sgd_pkg::ONE;
            endcase
            c_nxt = 3'd2;
          end
          3'd2: c_nxt = 3'd3;
          default: begin
            wr_en   = 1'b1;
            wr_data = w_upd;
            c_nxt   = 3'd0;
            if (n_r == 2'd2) begin
              n_nxt = 2'd0;
              if (k_r == KW'(mlp_sgd_pkg::H - 1)) begin
                st_nxt = mlp_sgd_pkg::ST_DONE;
              end else begin
                k_nxt  = k_r + 1'b1;
                st_nxt = mlp_sgd_pkg::ST_TK;
              end
            end else begin
              n_nxt = n_r + 1'b1;
            end
          end
        endcase
      end
      mlp_sgd_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          done_load = 1'b1;
          st_nxt    = mlp_sgd_pkg::ST_IDLE;
        end
      end
      default: st_nxt = mlp_sgd_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mlp_sgd_pkg::ST_IDLE;
      c_r         <= '0;
      k_r         <= '0;
      n_r         <= '0;
      j_r         <= '0;
      lr_r        <= mlp_sgd_pkg::LR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      c_r  <= c_nxt;
      k_r  <= k_nxt;
      n_r  <= n_nxt;
      j_r  <= j_nxt;
      if (cfg_valid && cfg_ready) lr_r <= cfg_data;
      if (done_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // build the result from the item's mode
  always_comb begin
    res = '0;
    case (item_r.mode)
      mlp_sgd_pkg::MODE_READ: res.read_word = rdw_r;
      mlp_sgd_pkg::MODE_WRITE: res = '0;
      default: begin
        res.out_0 = y_r[0];
        res.out_1 = y_r[1];
        res.out_2 = y_r[2];
        res.out_3 = y_r[3];
        res.out_4 = y_r[4];
        res.out_5 = y_r[5];
        if (item_r.mode == mlp_sgd_pkg::MODE_TRAIN) begin
          res.max_abs_error = (maxerr_r > 33'h07FFFFFFF) ? 31'h7FFFFFFF : maxerr_r[30:0];
        end
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_item;
      maxerr_r <= '0;
    end
    if (done_load) out_item_r <= res;
    case (st_r)
      mlp_sgd_pkg::ST_RD: begin
        if (c_r == 3'd1) rdw_r <= rd_data;
      end
      mlp_sgd_pkg::ST_FH: begin
        if (c_r == 3'd3) begin
          acc_r <= acc_sum;
          if (n_r == 2'd2) begin
            h_r[k_r[KI-1:0]] <= (acc_sum > ACCW'(0)) ? mlp_sgd_pkg::sat32(acc_sum) : 32'sd0;
            e_r[k_r[KI-1:0]] <= '0;
          end
        end
      end
      mlp_sgd_pkg::ST_FO: begin
        if (c_r == 3'd3) begin
          acc_r <= acc_sum;
          if (k_r == KW'(mlp_sgd_pkg::H)) y_r[j_r] <= mlp_sgd_pkg::sat32(acc_sum);
        end
      end
      mlp_sgd_pkg::ST_DS: begin
        if (c_r == 3'd0) begin
          delta_r <= delta_c;
          if (mag > maxerr_r) maxerr_r <= mag;
        end
        if (c_r == 3'd2) s_r <= OPW'(rnd);
      end
      mlp_sgd_pkg::ST_W2: begin
        if (c_r == 3'd1) wtmp_r <= rd_data;
        if (c_r == 3'd3) wnew_r <= w_upd;
        if (c_r == 3'd6) e_r[k_r[KI-1:0]] <= ek + ACCW'(rnd);
      end
      mlp_sgd_pkg::ST_TK: begin
        if (c_r == 3'd2) t_r <= OPW'(rnd);
      end
      mlp_sgd_pkg::ST_W1: begin
        if (c_r == 3'd1) wtmp_r <= rd_data;
      end
      default: ;
    endcase
  end

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("item taken while another is in progress");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mlp_sgd_pkg::ST_DONE && out_valid_r && out_stall) |=>
      (st_r == mlp_sgd_pkg::ST_DONE && out_valid_r))
    else $error("pending result overwritten");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr < mlp_sgd_pkg::AW'(mlp_sgd_pkg::N_WORDS)))
    else $error("weight write out of range");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mlp_sgd_pkg::ST_IDLE) |-> !wr_en)
    else $error("weight write while idle");

endmodule
